// ----- src/sorted_list_table_defines.svh -----
// ---------------------------------------------------------------------------
// Sorted list table assertion macros
// Shared property wrappers clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_DEFINES_SVH
`define SORTED_LIST_TABLE_DEFINES_SVH

// Same-cycle implication
`define SLT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted_list_table assertion failed");

// Next-cycle implication
`define SLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted_list_table assertion failed");

`endif

// ----- src/slt_pkg.sv -----
// ---------------------------------------------------------------------------
// Sorted list table package
// Action and status codes, controller command bundle and default sizes.
// ---------------------------------------------------------------------------
package slt_pkg;

  localparam int unsigned DEPTH_DEF      = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned ACTION_W       = 3;
  localparam int unsigned STATUS_W       = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT     = 3'd0,
    ACT_DELETE     = 3'd1,
    ACT_SEARCH     = 3'd2,
    ACT_GET_NEXT   = 3'd3,
    ACT_RESET_ITER = 3'd4,
    ACT_CLEAR      = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the accepted request
    logic cmp;     // run the parallel compare over the cell row
    logic commit;  // apply the action and load the response register
  } cmd_t;

endpackage

// ----- src/slt_req_if.sv -----
// ---------------------------------------------------------------------------
// Sorted list table request channel
// Valid/ready channel carrying one action and its operand.
// ---------------------------------------------------------------------------
interface slt_req_if #(
  parameter int unsigned VALUE_BITS = slt_pkg::VALUE_BITS_DEF
) ();
  logic                                valid;
  logic                                ready;
  logic [slt_pkg::ACTION_W-1:0]        action;
  logic signed [VALUE_BITS-1:0]        value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

// ----- src/slt_rsp_if.sv -----
// ---------------------------------------------------------------------------
// Sorted list table response channel
// Valid/ready channel carrying the result of one request.
// ---------------------------------------------------------------------------
interface slt_rsp_if #(
  parameter int unsigned VALUE_BITS = slt_pkg::VALUE_BITS_DEF,
  parameter int unsigned LEN_W      = $clog2(slt_pkg::DEPTH_DEF + 1)
) ();
  logic                                valid;
  logic                                ready;
  logic [slt_pkg::STATUS_W-1:0]        status;
  logic                                found;
  logic signed [VALUE_BITS-1:0]        read_value;
  logic [LEN_W-1:0]                    length;

  modport source (output valid, status, found, read_value, length, input ready);
  modport sink   (input valid, status, found, read_value, length, output ready);
endinterface

// ----- src/slt_ctrl.sv -----
// ---------------------------------------------------------------------------
// Sorted list table controller
// Sequences accept, compare and commit, and owns the response valid flag.
// ---------------------------------------------------------------------------
module slt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output slt_pkg::cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  state_e state_q;
  logic   rsp_valid_q;
  logic   rsp_free;
  logic   req_acc;

  // Response slot is free when empty or being taken this cycle
  assign rsp_free = !rsp_valid_q || rsp_ready_i;

  // Take a new request when idle or while the current one commits
  assign req_ready_o = (state_q == S_IDLE) || ((state_q == S_UPD) && rsp_free);
  assign req_acc     = req_valid_i && req_ready_o;

  assign cmd_o.load   = req_acc;
  assign cmd_o.cmp    = (state_q == S_CMP);
  assign cmd_o.commit = (state_q == S_UPD) && rsp_free;

  assign rsp_valid_o = rsp_valid_q;

  // State and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_acc) begin
            state_q <= S_CMP;
          end
          if (rsp_ready_i) begin
            rsp_valid_q <= 1'b0;
          end
        end
        S_CMP: begin
          state_q <= S_UPD;
          if (rsp_ready_i) begin
            rsp_valid_q <= 1'b0;
          end
        end
        S_UPD: begin
          if (rsp_free) begin
            rsp_valid_q <= 1'b1;
            state_q     <= req_acc ? S_CMP : S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/slt_datapath.sv -----
// ---------------------------------------------------------------------------
// Sorted list table datapath
// Row of value cells with parallel compare, shift-on-commit and response regs.
// ---------------------------------------------------------------------------
module slt_datapath #(
  parameter int unsigned DEPTH      = slt_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_BITS = slt_pkg::VALUE_BITS_DEF,
  parameter int unsigned LEN_W      = $clog2(DEPTH + 1),
  parameter int unsigned CUR_W      = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  slt_pkg::cmd_t                cmd_i,
  input  logic [slt_pkg::ACTION_W-1:0] action_i,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic [slt_pkg::STATUS_W-1:0] status_o,
  output logic                         found_o,
  output logic signed [VALUE_BITS-1:0] read_value_o,
  output logic [LEN_W-1:0]             length_o
);

  // Cells and table state
  logic signed [VALUE_BITS-1:0] cell_q [DEPTH];
  logic signed [VALUE_BITS-1:0] cell_d [DEPTH];
  logic [LEN_W-1:0]             count_q, count_d;
  logic [CUR_W-1:0]             cursor_q, cursor_d;

  // Request registers
  logic [slt_pkg::ACTION_W-1:0] act_q;
  logic signed [VALUE_BITS-1:0] val_q;

  // Compare results
  logic [DEPTH-1:0]             ge_d, ge_q, ge_prev;
  logic                         hit_d, hit_q;
  logic                         full_q;
  logic signed [VALUE_BITS-1:0] rd_d, rd_q;
  logic [CUR_W-1:0]             rd_idx;
  logic [CUR_W-1:0]             cur_next_d, cur_next_q;
  logic [LEN_W-1:0]             cur_inc;

  // Response registers
  slt_pkg::status_e             status_d, status_q;
  logic                         found_d, found_q;
  logic signed [VALUE_BITS-1:0] rdval_d, rdval_q;
  logic [LEN_W-1:0]             len_q;

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      val_q <= value_i;
    end
  end

  // Parallel compare: cells past the end count as not less than the key
  always_comb begin
    ge_d  = '0;
    hit_d = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      ge_d[i] = (LEN_W'(i) >= count_q) || (cell_q[i] >= val_q);
      if ((LEN_W'(i) < count_q) && (cell_q[i] == val_q)) begin
        hit_d = 1'b1;
      end
    end
  end

  // Cursor read: wrap to the front when the cursor sits past the end
  always_comb begin
    rd_idx = (LEN_W'(cursor_q) >= count_q) ? '0 : cursor_q;
    rd_d   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_d = rd_d | (cell_q[i] & {VALUE_BITS{CUR_W'(i) == rd_idx}});
    end
    cur_inc    = LEN_W'(rd_idx) + LEN_W'(1);
    cur_next_d = (cur_inc >= count_q) ? '0 : CUR_W'(cur_inc);
  end

  // Hold the compare stage results
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      ge_q       <= ge_d;
      hit_q      <= hit_d;
      full_q     <= (count_q == LEN_W'(DEPTH));
      rd_q       <= rd_d;
      cur_next_q <= cur_next_d;
    end
  end

  // Insert position is the first set bit of the mask
  assign ge_prev = {ge_q[DEPTH-2:0], 1'b0};

  // Apply the action
  always_comb begin
    cell_d   = cell_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    status_d = slt_pkg::ST_OK;
    found_d  = 1'b0;
    rdval_d  = '0;
    unique case (slt_pkg::action_e'(act_q))
      slt_pkg::ACT_INSERT: begin
        if (full_q) begin
          status_d = slt_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (ge_q[i]) begin
              cell_d[i] = ge_prev[i] ? cell_q[(i + DEPTH - 1) % DEPTH] : val_q;
            end
          end
          count_d = count_q + LEN_W'(1);
        end
      end
      slt_pkg::ACT_DELETE: begin
        if (hit_q) begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (ge_q[i]) begin
              cell_d[i] = cell_q[i + 1];
            end
          end
          count_d = count_q - LEN_W'(1);
          found_d = 1'b1;
        end else begin
          status_d = slt_pkg::ST_NOT_FOUND;
        end
      end
      slt_pkg::ACT_SEARCH: begin
        if (hit_q) begin
          found_d = 1'b1;
        end else begin
          status_d = slt_pkg::ST_NOT_FOUND;
        end
      end
      slt_pkg::ACT_GET_NEXT: begin
        if (count_q == '0) begin
          status_d = slt_pkg::ST_EMPTY;
        end else begin
          rdval_d  = rd_q;
          cursor_d = cur_next_q;
        end
      end
      slt_pkg::ACT_RESET_ITER: begin
        cursor_d = '0;
      end
      slt_pkg::ACT_CLEAR: begin
        count_d  = '0;
        cursor_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Cell row update
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      for (int i = 0; i < DEPTH; i++) begin
        cell_q[i] <= cell_d[i];
      end
    end
  end

  // Count and cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
    end else if (cmd_i.commit) begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      found_q  <= found_d;
      rdval_q  <= rdval_d;
      len_q    <= count_d;
    end
  end

  assign status_o     = status_q;
  assign found_o      = found_q;
  assign read_value_o = rdval_q;
  assign length_o     = len_q;

endmodule

// ----- src/sorted_list_table.sv -----
// Each request passes through a compare state and an update state; the response
//   valid flag is registered at commit, which waits while the response slot is
//   full. The compare spans the whole cell row, and the commit shifts the row.
// A request is taken during the commit cycle while the response slot is free.
// Reset clears length and iteration cursor at once; cell contents stay undefined.
// ---------------------------------------------------------------------------
// Sorted list table
// Ordered table of signed values with insert, delete, search and iteration.
// ---------------------------------------------------------------------------
`include "sorted_list_table_defines.svh"

module sorted_list_table #(
  parameter int unsigned DEPTH      = slt_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_BITS = slt_pkg::VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  slt_req_if.sink   req_i,
  slt_rsp_if.source rsp_o
);

  localparam int unsigned LEN_W = $clog2(DEPTH + 1);
  localparam int unsigned CUR_W = $clog2(DEPTH);

  slt_pkg::cmd_t cmd;

  // Controller
  slt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // Datapath
  slt_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .LEN_W      (LEN_W),
    .CUR_W      (CUR_W)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .action_i     (req_i.action),
    .value_i      (req_i.value),
    .status_o     (rsp_o.status),
    .found_o      (rsp_o.found),
    .read_value_o (rsp_o.read_value),
    .length_o     (rsp_o.length)
  );

  // Checks
  `SLT_ASSERT_NEXT(a_cmp_after_accept, req_i.valid && req_i.ready, !req_i.ready)
  `SLT_ASSERT_IMPL(a_len_bound, rsp_o.valid, rsp_o.length <= LEN_W'(DEPTH))
  `SLT_ASSERT_IMPL(a_empty_len, rsp_o.valid && (rsp_o.status == slt_pkg::ST_EMPTY), rsp_o.length == '0)
  `SLT_ASSERT_IMPL(a_full_len, rsp_o.valid && (rsp_o.status == slt_pkg::ST_FULL), rsp_o.length == LEN_W'(DEPTH))

endmodule

// ----- bench/tb_sorted_list_table.sv -----
// ---------------------------------------------------------------------------
// Sorted list table testbench
// Drives insert, delete, search, iteration and clear requests into the table,
// tracks the expected table contents and cursor alongside, and checks every
// response field against that prediction under varied sender and receiver
// idling.
// ---------------------------------------------------------------------------
module tb_sorted_list_table;
  import slt_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int unsigned VB    = VALUE_BITS_DEF;
  localparam int unsigned LEN_W = $clog2(DEPTH + 1);

  // Action codes outside the defined set: the table must ignore them
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam logic signed [VB-1:0] VAL_MIN  = {1'b1, {(VB-1){1'b0}}};
  localparam logic signed [VB-1:0] VAL_MAX  = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] VAL_ZERO = '0;
  localparam logic signed [VB-1:0] VAL_NEG1 = '1;

  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [ACTION_W-1:0]  action;
    logic signed [VB-1:0] value;
  } slt_request_t;

  typedef struct {
    status_e              status;
    logic                 found;
    logic signed [VB-1:0] read_value;
    logic [LEN_W-1:0]     length;
  } slt_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                 req_valid  = 1'b0;
  logic [ACTION_W-1:0]  req_action = '0;
  logic signed [VB-1:0] req_value  = '0;
  logic                 rsp_ready  = 1'b0;
  logic                 req_fire   = 1'b0;

  slt_request_t request_q[$];
  slt_result_t  pending_rsp_q[$];
  int           errors = 0;

  // Idle percentages for the current phase
  int send_idle_pct = 0;
  int rcv_stall_pct = 0;

  // Long receiver hold-off, requested by the stimulus and counted by the receiver
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Predicted table state
  logic signed [VB-1:0] tbl_entry[DEPTH];
  int                   tbl_count  = 0;
  int                   tbl_cursor = 0;

  logic signed [VB-1:0] value_pool[16];

  slt_req_if #(.VALUE_BITS(VB)) req_if ();
  slt_rsp_if #(.VALUE_BITS(VB), .LEN_W(LEN_W)) rsp_if ();

  assign req_if.valid  = req_valid;
  assign req_if.action = req_action;
  assign req_if.value  = req_value;
  assign rsp_if.ready  = rsp_ready;

  sorted_list_table #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VB)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the predicted table and return its response
  function automatic slt_result_t step_table(logic [ACTION_W-1:0] act,
                                             logic signed [VB-1:0] val);
    slt_result_t r;
    int pos;
    r.status     = ST_OK;
    r.found      = 1'b0;
    r.read_value = '0;
    case (act)
      ACT_INSERT: begin
        if (tbl_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_entry[pos] < val) pos++;
          for (int i = tbl_count; i > pos; i--) tbl_entry[i] = tbl_entry[i-1];
          tbl_entry[pos] = val;
          tbl_count++;
        end
      end
      ACT_DELETE, ACT_SEARCH: begin
        pos = 0;
        while (pos < tbl_count && tbl_entry[pos] != val) pos++;
        if (pos < tbl_count) begin
          r.found = 1'b1;
          if (act == ACT_DELETE) begin
            for (int i = pos; i + 1 < tbl_count; i++) tbl_entry[i] = tbl_entry[i+1];
            tbl_count--;
          end
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      ACT_GET_NEXT: begin
        if (tbl_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // The cursor follows positions, so deletes may leave it past the end
          if (tbl_cursor >= tbl_count) tbl_cursor = 0;
          r.read_value = tbl_entry[tbl_cursor];
          tbl_cursor++;
          if (tbl_cursor >= tbl_count) tbl_cursor = 0;
        end
      end
      ACT_RESET_ITER: tbl_cursor = 0;
      ACT_CLEAR: begin
        tbl_count  = 0;
        tbl_cursor = 0;
      end
      default: ;
    endcase
    r.length = LEN_W'(tbl_count);
    return r;
  endfunction

  // Sample both handshakes, check the response, predict the accepted request
  always @(posedge clk) begin
    slt_result_t exp_r;
    req_fire <= req_valid && req_if.ready;
    if (rst_n) begin
      if (rsp_if.valid && rsp_ready) begin
        if (pending_rsp_q.size() == 0) begin
          $error("response with no request outstanding");
          errors++;
        end else begin
          exp_r = pending_rsp_q.pop_front();
          if (rsp_if.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, rsp_if.status);
            errors++;
          end
          if (rsp_if.found !== exp_r.found) begin
            $error("found: expected %0d, got %0d", exp_r.found, rsp_if.found);
            errors++;
          end
          if (rsp_if.read_value !== exp_r.read_value) begin
            $error("read_value: expected %0d, got %0d", exp_r.read_value,
                   rsp_if.read_value);
            errors++;
          end
          if (rsp_if.length !== exp_r.length) begin
            $error("length: expected %0d, got %0d", exp_r.length, rsp_if.length);
            errors++;
          end
        end
      end
      if (req_valid && req_if.ready) begin
        pending_rsp_q.push_back(step_table(req_action, req_value));
      end
    end
  end

  // Offer the next request, holding it until taken
  always @(negedge clk) begin
    slt_request_t nxt;
    if (rst_n && (!req_valid || req_fire)) begin
      if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = request_q.pop_front();
        req_valid  <= 1'b1;
        req_action <= nxt.action;
        req_value  <= nxt.value;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Stall the response channel at random, or for a long stretch on request
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  task automatic push_req(logic [ACTION_W-1:0] act, logic signed [VB-1:0] val);
    slt_request_t r;
    r.action = act;
    r.value  = val;
    request_q.push_back(r);
  endtask

  // Mostly values from a small pool so deletes and searches hit
  function automatic logic signed [VB-1:0] pick_value();
    if ($urandom_range(0, 99) < 70) return value_pool[$urandom_range(0, 15)];
    return $urandom();
  endfunction

  // Queue well-formed sequences with random content, plus some noise
  task automatic queue_traffic(int n_items);
    int queued;
    int kind;
    int len;
    queued = 0;
    while (queued < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 62) begin
        len = $urandom_range(0, 99);
        if (len < 45)      push_req(ACT_INSERT, pick_value());
        else if (len < 65) push_req(ACT_DELETE, pick_value());
        else if (len < 80) push_req(ACT_SEARCH, pick_value());
        else if (len < 95) push_req(ACT_GET_NEXT, $urandom());
        else               push_req(ACT_RESET_ITER, $urandom());
        queued++;
      end else if (kind < 70) begin
        // Burst of inserts that can fill the table and push past full
        len = $urandom_range(40, 70);
        repeat (len) push_req(ACT_INSERT, pick_value());
        queued += len;
      end else if (kind < 80) begin
        // Walk the table from the front, often past the wrap
        len = $urandom_range(1, 70);
        push_req(ACT_RESET_ITER, $urandom());
        repeat (len) push_req(ACT_GET_NEXT, $urandom());
        queued += len + 1;
      end else if (kind < 88) begin
        // Drain, mixing iteration with deletes
        len = $urandom_range(5, 30);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) push_req(ACT_GET_NEXT, $urandom());
          else push_req(ACT_DELETE, pick_value());
        end
        queued += len;
      end else if (kind < 91) begin
        push_req(ACT_CLEAR, $urandom());
        queued++;
      end else begin
        // Spare action codes, which leave the table alone
        push_req(ACT_SPARE_LO + ACTION_W'($urandom_range(0, 1)), $urandom());
        queued++;
      end
    end
  endtask

  // Wait until everything queued has been taken and answered
  task automatic wait_drained();
    while (request_q.size() != 0 || req_valid || pending_rsp_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic run_phase(int send_pct, int rcv_pct, int n_items);
    send_idle_pct = send_pct;
    rcv_stall_pct = rcv_pct;
    queue_traffic(n_items);
    wait_drained();
  endtask

  initial begin
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = VAL_ZERO;
    value_pool[3] = VAL_NEG1;
    value_pool[4] = 1;
    for (int i = 5; i < 16; i++) value_pool[i] = $urandom();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, extremes, duplicate of the head, cursor past the end
    push_req(ACT_GET_NEXT, VAL_ZERO);
    push_req(ACT_DELETE, 5);
    push_req(ACT_SEARCH, 5);
    push_req(ACT_INSERT, VAL_ZERO);
    push_req(ACT_INSERT, VAL_MAX);
    push_req(ACT_INSERT, VAL_MIN);
    push_req(ACT_INSERT, VAL_MIN);
    push_req(ACT_INSERT, VAL_NEG1);
    push_req(ACT_SEARCH, VAL_MAX);
    push_req(ACT_SEARCH, 1);
    push_req(ACT_GET_NEXT, VAL_MAX);
    push_req(ACT_GET_NEXT, VAL_MIN);
    push_req(ACT_DELETE, VAL_MIN);
    push_req(ACT_DELETE, VAL_MIN);
    push_req(ACT_DELETE, VAL_ZERO);
    push_req(ACT_GET_NEXT, VAL_ZERO);
    push_req(ACT_GET_NEXT, VAL_ZERO);
    push_req(ACT_GET_NEXT, VAL_ZERO);
    push_req(ACT_RESET_ITER, VAL_NEG1);
    push_req(ACT_GET_NEXT, VAL_ZERO);
    push_req(ACT_SPARE_LO, VAL_MAX);
    push_req(ACT_SPARE_HI, VAL_MIN);
    push_req(ACT_INSERT, 32'h5555_5555);
    push_req(ACT_CLEAR, VAL_NEG1);
    push_req(ACT_GET_NEXT, VAL_ZERO);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_req = hold_req + 1;
    run_phase(0, 0, 400);
    run_phase(83, 0, 400);
    run_phase(0, 83, 400);
    run_phase(28, 28, 420);

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule
